>>> src/ipid_pkg.sv
// Package with the shared types and constants of the incremental PID heater.
`default_nettype none

package ipid_pkg;

    localparam int GAIN_W  = 8;
    localparam int VALUE_W = 16;
    localparam int ERR_W   = 7;
    localparam int DRIVE_W = 7;
    localparam int CFG_IDX_W = 2;

    // Worst-case sum magnitude is about 255 * (127 + 127 + 254) + 100, so 20 signed bits hold it.
    localparam int SUM_W = 20;

    localparam logic [DRIVE_W-1:0] DRIVE_MAX = 7'd100;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D = 2'd2;

    localparam logic [GAIN_W-1:0] GAIN_P_RESET = 8'd2;
    localparam logic [GAIN_W-1:0] GAIN_I_RESET = 8'd1;
    localparam logic [GAIN_W-1:0] GAIN_D_RESET = 8'd1;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
    } gains_t;

    typedef struct packed {
        logic [ERR_W-1:0]   error_now;
        logic [ERR_W-1:0]   error_last;
        logic [ERR_W-1:0]   error_before_last;
        logic [DRIVE_W-1:0] drive_last;
    } pid_state_t;

endpackage

`default_nettype wire

>>> src/incremental_pid_heater.sv
// Top level of the incremental PID heater drive controller.
`default_nettype none

// Incremental PID heater controller. Each item carries a setpoint and a
// measured value and yields exactly one drive level from 0 to 100. When
// the measured value is at or above the setpoint the drive is 0; when the
// error exceeds 100 the drive is 100; in both cases the error history is
// kept. Otherwise the error enters a three-sample history and the drive is
// the previous drive plus the P, I and D increments, clamped to 0..100.
// Timing: an item is taken into an input register, the drive is computed
// from it by one pass of three small multiplies, an adder and a clamp,
// and lands in the output register. One item is accepted every cycle as
// long as the output side keeps taking results. The gains are to be
// written through the configuration port only while the block is idle,
// which the block itself does not enforce; index 0 is the P gain, 1 the
// I gain, 2 the D gain, and writes to other indexes are ignored.

module incremental_pid_heater (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              cfg_write,
    input  wire logic [ipid_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ipid_pkg::GAIN_W-1:0]       cfg_data,

    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [ipid_pkg::VALUE_W-1:0]      setpoint,
    input  wire logic [ipid_pkg::VALUE_W-1:0]      measured,

    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [ipid_pkg::DRIVE_W-1:0]           drive
);

    ipid_pkg::gains_t                  gains_reg;
    ipid_pkg::pid_state_t              state_reg;
    ipid_pkg::pid_state_t              state_next;

    logic                              in_valid_reg;
    logic [ipid_pkg::VALUE_W-1:0]      setpoint_reg;
    logic [ipid_pkg::VALUE_W-1:0]      measured_reg;

    logic                              out_valid_reg;
    logic [ipid_pkg::DRIVE_W-1:0]      drive_reg;
    logic [ipid_pkg::DRIVE_W-1:0]      drive_next;

    logic                              advance;
    logic                              compute;

    // The pipeline moves whenever the output register is empty or its item
    // is being taken this cycle.
    assign advance  = !out_valid_reg || out_ready;
    assign compute  = advance && in_valid_reg;
    assign in_ready = !in_valid_reg || advance;

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

    // Gain registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.gain_p <= ipid_pkg::GAIN_P_RESET;
            gains_reg.gain_i <= ipid_pkg::GAIN_I_RESET;
            gains_reg.gain_d <= ipid_pkg::GAIN_D_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ipid_pkg::CFG_GAIN_P: gains_reg.gain_p <= cfg_data;
                ipid_pkg::CFG_GAIN_I: gains_reg.gain_i <= cfg_data;
                ipid_pkg::CFG_GAIN_D: gains_reg.gain_d <= cfg_data;
                default:              gains_reg <= gains_reg;
            endcase
        end
    end

    // Input register stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            setpoint_reg <= setpoint;
            measured_reg <= measured;
        end
    end

    ipid_calc u_calc (
        .setpoint   (setpoint_reg),
        .measured   (measured_reg),
        .gains      (gains_reg),
        .state      (state_reg),
        .state_next (state_next),
        .drive      (drive_next)
    );

    // History and previous drive advance together with the result register,
    // so the next item always sees the state this one left behind.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (compute)
            begin
                state_reg <= state_next;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (compute)
        begin
            drive_reg <= drive_next;
        end
    end

endmodule

`default_nettype wire

>>> src/ipid_calc.sv
// Combinational drive computation for one item: error, PID sum and clamp.
`default_nettype none

module ipid_calc (
    input  wire logic [ipid_pkg::VALUE_W-1:0] setpoint,
    input  wire logic [ipid_pkg::VALUE_W-1:0] measured,
    input  wire ipid_pkg::gains_t             gains,
    input  wire ipid_pkg::pid_state_t         state,
    output ipid_pkg::pid_state_t              state_next,
    output logic [ipid_pkg::DRIVE_W-1:0]      drive
);

    localparam int SW = ipid_pkg::SUM_W;

    logic [ipid_pkg::VALUE_W:0]       diff;
    logic                             at_or_above;
    logic                             too_far;
    logic [ipid_pkg::ERR_W-1:0]       e0;
    logic signed [SW-1:0]             e0_s;
    logic signed [SW-1:0]             e1_s;
    logic signed [SW-1:0]             e2_s;
    logic signed [SW-1:0]             gp_s;
    logic signed [SW-1:0]             gi_s;
    logic signed [SW-1:0]             gd_s;
    logic signed [SW-1:0]             term_p;
    logic signed [SW-1:0]             term_i;
    logic signed [SW-1:0]             term_d;
    logic signed [SW-1:0]             sum;
    logic [ipid_pkg::DRIVE_W-1:0]     pid_drive;

    assign diff        = {1'b0, setpoint} - {1'b0, measured};
    assign at_or_above = (setpoint <= measured);
    assign too_far     = (diff > {{(ipid_pkg::VALUE_W+1-ipid_pkg::DRIVE_W){1'b0}},
                                  ipid_pkg::DRIVE_MAX});
    assign e0          = diff[ipid_pkg::ERR_W-1:0];

    assign e0_s = $signed({{(SW-ipid_pkg::ERR_W){1'b0}}, e0});
    assign e1_s = $signed({{(SW-ipid_pkg::ERR_W){1'b0}}, state.error_now});
    assign e2_s = $signed({{(SW-ipid_pkg::ERR_W){1'b0}}, state.error_last});
    assign gp_s = $signed({{(SW-ipid_pkg::GAIN_W){1'b0}}, gains.gain_p});
    assign gi_s = $signed({{(SW-ipid_pkg::GAIN_W){1'b0}}, gains.gain_i});
    assign gd_s = $signed({{(SW-ipid_pkg::GAIN_W){1'b0}}, gains.gain_d});

    // The error entering the history becomes e0; the old e0 and e1 move down one place.
    assign term_p = gp_s * (e0_s - e1_s);
    assign term_i = gi_s * e0_s;
    assign term_d = gd_s * (e0_s - (e1_s <<< 1) + e2_s);
    assign sum    = $signed({{(SW-ipid_pkg::DRIVE_W){1'b0}}, state.drive_last})
                  + term_p + term_i + term_d;

    always_comb
    begin
        if (sum <= 0)
        begin
            pid_drive = '0;
        end
        else if (sum >= $signed({{(SW-ipid_pkg::DRIVE_W){1'b0}}, ipid_pkg::DRIVE_MAX}))
        begin
            pid_drive = ipid_pkg::DRIVE_MAX;
        end
        else
        begin
            pid_drive = sum[ipid_pkg::DRIVE_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state;
        if (at_or_above)
        begin
            drive = '0;
        end
        else if (too_far)
        begin
            drive = ipid_pkg::DRIVE_MAX;
        end
        else
        begin
            drive                        = pid_drive;
            state_next.error_now         = e0;
            state_next.error_last        = state.error_now;
            state_next.error_before_last = state.error_last;
        end
        state_next.drive_last = drive;
    end

endmodule

`default_nettype wire
